// ===== rtl/scml_pkg.sv =====
// ----------------------------------------------------------------------------
// scml_pkg
// Shared types and constants of the sorted code map lookup block.
// ----------------------------------------------------------------------------
package scml_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W       = 24;
  localparam int VAL_W       = 20;
  localparam int ENTRY_W     = KEY_W + VAL_W;

  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CHK,
    ST_CHK_DATA,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] unicode_out;
    logic             duplicate_key;
    logic             table_full;
  } result_t;

endpackage

// ===== rtl/sorted_code_map_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_code_map_lookup
// Sorted (key, value) code table with insert and binary-search lookup.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-------------
//  s_axis   | in  | cns_key[23:0], unicode_value[43:24], pad    | func
//  m_axis   | out | found[0], unicode_out[20:1], duplicate_key  | -
//           |     | [21], table_full[22], pad                   |
//
//  Each search step is a RAM read, then a compare. A lookup runs one search
//  and a presence check. An insert runs two searches (one if the table is
//  full), then moves every entry behind the insert point up one row, a read
//  and a write each, plus one write of the new entry. Reset clears the state,
//  the entry count and the output valid flag; the RAM is not swept.
//  s_axis_tready is high only between items; a result held in the output
//  register does not block the next beat unless it is still unread when the
//  following result is ready.
// ----------------------------------------------------------------------------
module sorted_code_map_lookup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cns_key[23:0], unicode_value[43:24], zero pad [47:44]
  input  logic [scml_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // found[0], unicode_out[20:1], duplicate_key[21], table_full[22], pad[23]
  output logic [scml_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import scml_pkg::*;

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  result_t            res;

  // Sequencer: owns the search window, the entry count and the result register.
  scml_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata[KEY_W-1:0]),
    .in_val_i    (s_axis_tdata[ENTRY_W-1:KEY_W]),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Table storage: key in the upper bits, value in the lower bits of a row.
  scml_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Pack the result beat, lowest field first.
  assign m_axis_tdata = {
    (OUT_DATA_W - VAL_W - 3)'(0),
    res.table_full,
    res.duplicate_key,
    res.unicode_out,
    res.found
  };

  // Accepting a beat starts a multi-cycle search: the port must drop ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a search was running");

  // A lookup hit never carries insert flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[21] && !m_axis_tdata[22])
    else $error("lookup hit carries insert flags");

  // A miss or an insert returns a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[20:1] == '0)
    else $error("nonzero value without a hit");

endmodule

// ===== rtl/scml_ram.sv =====
// ----------------------------------------------------------------------------
// scml_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/scml_cmp.sv =====
// ----------------------------------------------------------------------------
// scml_cmp
// Shared order compare: is the stored (key, value) below the probe pair.
// ----------------------------------------------------------------------------
module scml_cmp (
  input  logic [scml_pkg::KEY_W-1:0] entry_key_i,
  input  logic [scml_pkg::VAL_W-1:0] entry_val_i,
  input  logic [scml_pkg::KEY_W-1:0] probe_key_i,
  input  logic [scml_pkg::VAL_W-1:0] probe_val_i,
  input  logic                       after_i,
  output logic                       below_o
);
  import scml_pkg::*;

  // With after_i set, equal pairs count as below so the search lands past them.
  always_comb begin
    if (entry_key_i != probe_key_i) begin
      below_o = entry_key_i < probe_key_i;
    end else if (after_i) begin
      below_o = entry_val_i <= probe_val_i;
    end else begin
      below_o = entry_val_i < probe_val_i;
    end
  end

endmodule

// ===== rtl/scml_ctrl.sv =====
// ----------------------------------------------------------------------------
// scml_ctrl
// Sequencer: binary search, presence check, tail shift and insert write.
// ----------------------------------------------------------------------------
module scml_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_func_i,
  input  logic [scml_pkg::KEY_W-1:0]   in_key_i,
  input  logic [scml_pkg::VAL_W-1:0]   in_val_i,
  output scml_pkg::mem_req_t           mem_req_o,
  input  logic [scml_pkg::ENTRY_W-1:0] mem_rdata_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output scml_pkg::result_t            res_o
);
  import scml_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d, idx_q, idx_d, count_q, count_d;
  logic               pass_q, pass_d;
  logic               func_q, func_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   val_q, val_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [CNT_W-1:0]   mid;
  logic               below;
  logic               hit;
  logic               table_is_full;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;

  assign mid           = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_key        = mem_rdata_i[ENTRY_W-1:VAL_W];
  assign rd_val        = mem_rdata_i[VAL_W-1:0];
  assign hit           = rd_key == key_q;
  assign table_is_full = count_q == CNT_W'(TABLE_DEPTH);

  scml_cmp u_cmp (
    .entry_key_i (rd_key),
    .entry_val_i (rd_val),
    .probe_key_i (key_q),
    .probe_val_i (pass_q ? val_q : '0),
    .after_i     (pass_q),
    .below_o     (below)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (lo_q < hi_q)  state_d = ST_CMP;
        else if (!pass_q) state_d = ST_CHK;
        else              state_d = ST_SHIFT_RD;
      end
      ST_CMP: state_d = ST_PROBE;
      ST_CHK: begin
        if (lo_q < count_q) begin
          state_d = ST_CHK_DATA;
        end else if (func_q == FUNC_LOOKUP || table_is_full) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_CHK_DATA: begin
        if (func_q == FUNC_LOOKUP || table_is_full) state_d = ST_DONE;
        else                                        state_d = ST_PROBE;
      end
      ST_SHIFT_RD: begin
        if (idx_q > lo_q) state_d = ST_SHIFT_WR;
        else              state_d = ST_WRITE;
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_WRITE:    state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    count_d     = count_q;
    pass_d      = pass_q;
    func_d      = func_q;
    key_d       = key_q;
    val_d       = val_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    mem_req_o   = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d = in_func_i;
          key_d  = in_key_i;
          val_d  = in_val_i;
          lo_d   = '0;
          hi_d   = count_q;
          pass_d = 1'b0;
          res_d  = '0;
        end
      end
      ST_PROBE: begin
        mem_req_o.raddr = mid[ADDR_W-1:0];
        if (!(lo_q < hi_q) && pass_q) idx_d = count_q;
      end
      ST_CMP: begin
        if (below) lo_d = mid + CNT_W'(1);
        else       hi_d = mid;
      end
      ST_CHK: begin
        mem_req_o.raddr = lo_q[ADDR_W-1:0];
        if (!(lo_q < count_q)) begin
          res_d.table_full = (func_q == FUNC_INSERT) && table_is_full;
          lo_d   = '0;
          hi_d   = count_q;
          pass_d = 1'b1;
        end
      end
      ST_CHK_DATA: begin
        if (func_q == FUNC_LOOKUP) begin
          res_d.found       = hit;
          res_d.unicode_out = hit ? rd_val : '0;
        end else begin
          res_d.duplicate_key = hit;
          res_d.table_full    = table_is_full;
        end
        lo_d   = '0;
        hi_d   = count_q;
        pass_d = 1'b1;
      end
      ST_SHIFT_RD: begin
        mem_req_o.raddr = ADDR_W'(idx_q - CNT_W'(1));
      end
      ST_SHIFT_WR: begin
        // Move one entry up by one; idx stays below the depth here.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[ADDR_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_q - CNT_W'(1);
      end
      ST_WRITE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = lo_q[ADDR_W-1:0];
        mem_req_o.wdata = {key_q, val_q};
        count_d         = count_q + CNT_W'(1);
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    idx_q  <= idx_d;
    pass_q <= pass_d;
    func_q <= func_d;
    key_q  <= key_d;
    val_q  <= val_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
